FILE: rtl/tpaf_pkg.sv
package tpaf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int DELAY_W  = 14;
    localparam int PULSE_W  = 10;

    localparam logic [SAMPLE_W-1:0] ADC_CODE_MAX = 12'd4095;

    // Values after reset
    localparam logic [PULSE_W-1:0] PULSE_WIDTH_RST = 10'd25;
    localparam logic [DELAY_W-1:0] DELAY_MIN_RST   = 14'd100;
    localparam logic [DELAY_W-1:0] DELAY_MAX_RST   = 14'd9900;
    localparam logic [DELAY_W-1:0] DELAY_RST       = 14'd9900;

    // Word kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_ZC   = 2'd1,
        MODE_ADC  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic               warn;
        logic               busy;
        logic               gate;
    } t_result;

endpackage

FILE: rtl/tpaf_map.sv
module tpaf_map
    import tpaf_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic               i_clk,
    input  logic               i_en_prod,
    input  logic               i_en_map,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [DELAY_W-1:0] i_delay_min,
    input  logic [DELAY_W-1:0] i_delay_max,
    output logic [DELAY_W-1:0] o_map
);

    // Largest sample that reaches the multiplier
    localparam int CLAMP_INT = (ADC_FULL_SCALE < 4095) ? ADC_FULL_SCALE : 4095;
    localparam logic [SAMPLE_W-1:0] CLAMP = SAMPLE_W'(CLAMP_INT);
    localparam int SPAN_MAX  = (1 << DELAY_W) - 1;
    // Bits of sample * span
    localparam int PROD_W    = $clog2(CLAMP_INT * SPAN_MAX + 1);
    // Exact floor division by reciprocal: m = ceil(2^k / d), k = n + ceil(log2 d)
    localparam int SHIFT     = PROD_W + $clog2(ADC_FULL_SCALE);
    localparam int RECIP_W   = PROD_W + 1;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);
    localparam int WIDE_W    = PROD_W + RECIP_W;

    logic [SAMPLE_W-1:0] w_sample;
    logic [DELAY_W-1:0]  w_span;
    logic [PROD_W-1:0]   n_prod;
    logic [PROD_W-1:0]   r_prod;
    logic [WIDE_W-1:0]   w_wide;
    logic [DELAY_W-1:0]  w_quo;
    logic [DELAY_W:0]    w_sum;
    logic [DELAY_W-1:0]  n_map;
    logic [DELAY_W-1:0]  r_map;

    always_comb begin
        w_sample = (i_sample > CLAMP) ? CLAMP : i_sample;
        w_span   = (i_delay_max > i_delay_min) ? (i_delay_max - i_delay_min) : '0;
        n_prod   = PROD_W'(w_sample) * PROD_W'(w_span);
    end

    always_comb begin
        w_wide = WIDE_W'(r_prod) * WIDE_W'(RECIP);
        w_quo  = DELAY_W'(w_wide >> SHIFT);
        w_sum  = {1'b0, i_delay_min} + {1'b0, w_quo};
        // saturate at the top of the delay range
        n_map  = w_sum[DELAY_W] ? {DELAY_W{1'b1}} : w_sum[DELAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_prod <= n_prod;
        end
        if (i_en_map) begin
            r_map <= n_map;
        end
    end

    assign o_map = r_map;

endmodule

FILE: rtl/tpaf_ctrl.sv
module tpaf_ctrl
    import tpaf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [1:0]         i_mode,
    input  logic [DELAY_W-1:0] i_map,
    input  logic [PULSE_W-1:0] i_pulse_width,
    output t_result            o_res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_PULSE = 2'd2
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [DELAY_W-1:0] r_tick_count, n_tick_count;
    logic [DELAY_W-1:0] r_latched, n_latched;
    logic [DELAY_W-1:0] r_current, n_current;
    logic               r_gate, n_gate;
    logic               n_warn;
    t_result            r_res, n_res;
    logic [DELAY_W-1:0] w_tick_inc;

    assign w_tick_inc = r_tick_count + 14'd1;

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_latched    = r_latched;
        n_current    = r_current;
        n_gate       = r_gate;
        n_warn       = 1'b0;
        case (i_mode)
            MODE_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_tick_count = w_tick_inc;
                    if (w_tick_inc >= r_latched) begin
                        n_gate       = 1'b1;
                        n_phase      = PH_PULSE;
                        n_tick_count = '0;
                    end
                end else if (r_phase == PH_PULSE) begin
                    n_tick_count = w_tick_inc;
                    if (w_tick_inc >= DELAY_W'(i_pulse_width)) begin
                        n_gate       = 1'b0;
                        n_phase      = PH_IDLE;
                        n_tick_count = '0;
                    end
                end
            end
            MODE_ZC: begin
                if (r_phase == PH_IDLE) begin
                    n_latched    = r_current;
                    n_tick_count = '0;
                    // zero delay fires on the crossing itself
                    if (r_current == '0) begin
                        n_gate  = 1'b1;
                        n_phase = PH_PULSE;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end else begin
                    n_warn = 1'b1;
                end
            end
            MODE_ADC: begin
                n_current = i_map;
            end
            default: begin
            end
        endcase
        n_res.gate  = n_gate;
        n_res.busy  = (n_phase != PH_IDLE);
        n_res.warn  = n_warn;
        n_res.delay = n_current;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_latched    <= DELAY_RST;
            r_current    <= DELAY_RST;
            r_gate       <= 1'b0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_latched    <= n_latched;
            r_current    <= n_current;
            r_gate       <= n_gate;
            r_res        <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/triac_phase_angle_firing_unit.sv
// Phase-angle triac firing controller. Each input word is a 1 us tick, a mains
// zero crossing or a 12-bit ADC sample, selected by s_axis_tuser; every word
// yields exactly one result word giving the gate level, the busy flag, an
// overlap warning and the current firing delay after that word. A sample maps
// to delay_min + sample*(delay_max-delay_min)/ADC_FULL_SCALE (span zero when
// delay_max is below delay_min); a crossing while idle latches that delay, the
// gate rises after that many ticks and stays high for pulse_width ticks. A
// crossing while busy is dropped and flagged. Throughput is one word per clock
// while m_axis_tready accepts results; a result passes four registers:
// input register, the sample*span multiply, the reciprocal multiply that replaces
// the division by the full-scale constant, and the state update into the result
// register. Each stage holds only while the one after it is full and stalled, so
// input keeps flowing into empty stages while a result waits on m_axis_tready.
// Registers sit on the APB port at 0x0 pulse_width, 0x4 delay_min, 0x8
// delay_max; write them only while no word is in flight.
module triac_phase_angle_firing_unit
    import tpaf_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] gate_drive, [1] busy_res, [2] overlap_warning, [16:3] fire_delay, [23:17] zero
    output logic [23:0] m_axis_tdata
);

    localparam logic [1:0] REG_PULSE_WIDTH = 2'd0;
    localparam logic [1:0] REG_DELAY_MIN   = 2'd1;
    localparam logic [1:0] REG_DELAY_MAX   = 2'd2;

    logic [PULSE_W-1:0]  r_pulse_width;
    logic [DELAY_W-1:0]  r_delay_min;
    logic [DELAY_W-1:0]  r_delay_max;
    logic                w_cfg_wr;

    logic                r_v1, r_v2, r_v3, r_out_valid;
    logic [1:0]          r_mode1, r_mode2, r_mode3;
    logic [SAMPLE_W-1:0] r_sample1;
    logic                w_rdy_out, w_rdy3, w_rdy2, w_rdy1;
    logic [DELAY_W-1:0]  w_map;
    t_result             w_res;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= PULSE_WIDTH_RST;
            r_delay_min   <= DELAY_MIN_RST;
            r_delay_max   <= DELAY_MAX_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_PULSE_WIDTH: r_pulse_width <= pwdata[PULSE_W-1:0];
                REG_DELAY_MIN:   r_delay_min   <= pwdata[DELAY_W-1:0];
                REG_DELAY_MAX:   r_delay_max   <= pwdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PULSE_WIDTH: prdata = 32'(r_pulse_width);
            REG_DELAY_MIN:   prdata = 32'(r_delay_min);
            REG_DELAY_MAX:   prdata = 32'(r_delay_max);
            default:         prdata = '0;
        endcase
    end

    // Stage advance: a stage loads whenever it is empty or the next one loads
    assign w_rdy_out     = !r_out_valid || m_axis_tready;
    assign w_rdy3        = !r_v3 || w_rdy_out;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Word kind and sample travel alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_mode1   <= s_axis_tuser;
            r_sample1 <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (w_rdy2) begin
            r_mode2 <= r_mode1;
        end
        if (w_rdy3) begin
            r_mode3 <= r_mode2;
        end
    end

    tpaf_map #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_map (
        .i_clk       (i_clk),
        .i_en_prod   (w_rdy2),
        .i_en_map    (w_rdy3),
        .i_sample    (r_sample1),
        .i_delay_min (r_delay_min),
        .i_delay_max (r_delay_max),
        .o_map       (w_map)
    );

    // Apply the word to the firing state as it enters the result register
    tpaf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_rdy_out && r_v3),
        .i_mode        (r_mode3),
        .i_map         (w_map),
        .i_pulse_width (r_pulse_width),
        .o_res         (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, w_res};

endmodule

FILE: bench/triac_phase_angle_firing_unit_tb.sv
module triac_phase_angle_firing_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpaf_pkg::*;

    // Register map on the APB port
    localparam logic [3:0] REG_PULSE_WIDTH = 4'h0;
    localparam logic [3:0] REG_DELAY_MIN   = 4'h4;
    localparam logic [3:0] REG_DELAY_MAX   = 4'h8;

    // Word kind that the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int DELAY_LIMIT   = (1 << DELAY_W) - 1;
    // Mapped delays above this make a firing cycle too slow for the random part
    localparam int LONG_DELAY    = 300;
    // Pipeline depth is four; leave some margin before touching registers
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1_000_000;
    // Words per random phase
    localparam int PHASE_WORDS   = 70;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WAIT = 2'd1,
        ST_FIRE = 2'd2
    } t_fire_state;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [11:0] adc_sample, [15:12] zero
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] gate_drive, [1] busy_res, [2] overlap_warning, [16:3] fire_delay, [23:17] zero
    logic [23:0] m_axis_tdata;

    // Predictor copy of the registers
    logic [PULSE_W-1:0] cfg_pulse_width = PULSE_WIDTH_RST;
    logic [DELAY_W-1:0] cfg_delay_min   = DELAY_MIN_RST;
    logic [DELAY_W-1:0] cfg_delay_max   = DELAY_MAX_RST;

    // Predictor copy of the firing state
    t_fire_state        fire_state   = ST_IDLE;
    logic [DELAY_W-1:0] tick_cnt     = '0;
    logic [DELAY_W-1:0] armed_delay  = DELAY_RST;
    logic [DELAY_W-1:0] mapped_delay = DELAY_RST;
    logic               gate_on      = 1'b0;

    t_result awaited_results[$];
    t_result seen_word;
    t_result want_word;

    int  fail_count  = 0;
    int  words_sent  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    // Set to run both sides back to back with no gaps
    bit  no_idle     = 1'b0;

    triac_phase_angle_firing_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Linear map of a sample onto the delay range, truncating division,
    // span forced to zero when the range is inverted.
    function automatic logic [DELAY_W-1:0] map_to_delay(input logic [SAMPLE_W-1:0] s);
        int span;
        int v;
        span = (cfg_delay_max > cfg_delay_min) ? int'(cfg_delay_max) - int'(cfg_delay_min) : 0;
        v    = int'(cfg_delay_min) + (int'(s) * span) / int'(ADC_CODE_MAX);
        return (v > DELAY_LIMIT) ? DELAY_W'(DELAY_LIMIT) : DELAY_W'(v);
    endfunction

    function automatic void open_gate();
        gate_on    = 1'b1;
        fire_state = ST_FIRE;
        tick_cnt   = '0;
    endfunction

    // Advance the firing state by one word and return the result it causes
    function automatic t_result advance_firing(input logic [1:0] mode,
                                               input logic [SAMPLE_W-1:0] s);
        t_result r;
        logic    warn;
        warn = 1'b0;
        case (mode)
            MODE_TICK: begin
                // Ticks count only while busy
                if (fire_state == ST_WAIT) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= armed_delay)
                        open_gate();
                end else if (fire_state == ST_FIRE) begin
                    tick_cnt = tick_cnt + 1'b1;
                    // A zero pulse width behaves as one
                    if (tick_cnt >= {{(DELAY_W-PULSE_W){1'b0}}, cfg_pulse_width}) begin
                        gate_on    = 1'b0;
                        fire_state = ST_IDLE;
                        tick_cnt   = '0;
                    end
                end
            end
            MODE_ZC: begin
                if (fire_state == ST_IDLE) begin
                    armed_delay = mapped_delay;
                    tick_cnt    = '0;
                    // Zero delay fires on the crossing itself
                    if (armed_delay == '0)
                        open_gate();
                    else
                        fire_state = ST_WAIT;
                end else begin
                    warn = 1'b1;
                end
            end
            MODE_ADC: mapped_delay = map_to_delay(s);
            default: ;
        endcase
        r.gate  = gate_on;
        r.busy  = (fire_state != ST_IDLE);
        r.warn  = warn;
        r.delay = mapped_delay;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    // Hold tready low for stalls that are mostly short, sometimes long
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
                                                         : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_word = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (awaited_results.size() == 0) begin
                $display("%0t: result word 0x%h arrived with nothing expected",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want_word = awaited_results.pop_front();
                if (seen_word.gate !== want_word.gate) begin
                    $display("%0t: gate_drive expected %0d actual %0d",
                             $time, want_word.gate, seen_word.gate);
                    fail_count++;
                end
                if (seen_word.busy !== want_word.busy) begin
                    $display("%0t: busy_res expected %0d actual %0d",
                             $time, want_word.busy, seen_word.busy);
                    fail_count++;
                end
                if (seen_word.warn !== want_word.warn) begin
                    $display("%0t: overlap_warning expected %0d actual %0d",
                             $time, want_word.warn, seen_word.warn);
                    fail_count++;
                end
                if (seen_word.delay !== want_word.delay) begin
                    $display("%0t: fire_delay expected %0d actual %0d",
                             $time, want_word.delay, seen_word.delay);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side and register access
    // ------------------------------------------------------------------

    // Gap before a word: none most of the time, a few cycles often, long rarely
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one word, wait for the handshake, then record its prediction.
    // Drop tvalid only when a gap follows, so back-to-back words stay high.
    task automatic send_word(input logic [1:0] mode, input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, s};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_results.push_back(advance_firing(mode, s));
        words_sent++;
    endtask

    // Stop offering words and let every result drain out of the pipeline
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [3:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [3:0] addr, input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== want) begin
            $display("%0t: register 0x%h expected %0d actual %0d", $time, addr, want, rd);
            fail_count++;
        end
    endtask

    // Write all three registers with the block idle, then read them back
    task automatic write_settings(input logic [PULSE_W-1:0] pw,
                                  input logic [DELAY_W-1:0] dmin,
                                  input logic [DELAY_W-1:0] dmax);
        logic [31:0] rd;
        settle_block();
        apb_access(1'b1, REG_PULSE_WIDTH, 32'(pw), rd);
        apb_access(1'b1, REG_DELAY_MIN, 32'(dmin), rd);
        apb_access(1'b1, REG_DELAY_MAX, 32'(dmax), rd);
        cfg_pulse_width = pw;
        cfg_delay_min   = dmin;
        cfg_delay_max   = dmax;
        check_register(REG_PULSE_WIDTH, 32'(pw));
        check_register(REG_DELAY_MIN, 32'(dmin));
        check_register(REG_DELAY_MAX, 32'(dmax));
    endtask

    // Tick until the wait and the pulse are over
    task automatic run_out_pulse();
        while (fire_state != ST_IDLE)
            send_word(MODE_TICK, SAMPLE_W'($urandom));
    endtask

    // Random words of any kind; never start a long wait from idle
    task automatic send_noise(input int n);
        logic [1:0] m;
        repeat (n) begin
            m = 2'($urandom_range(0, 3));
            if (m == MODE_ZC && fire_state == ST_IDLE && mapped_delay > LONG_DELAY)
                m = MODE_TICK;
            send_word(m, SAMPLE_W'($urandom));
        end
    endtask

    // One well-formed firing cycle: maybe a new sample, a crossing, then
    // ticks with some noise mixed in until the pulse has ended
    task automatic fire_cycle();
        logic [SAMPLE_W-1:0] s;
        if ($urandom_range(0, 9) < 7 || mapped_delay > LONG_DELAY) begin
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = ADC_CODE_MAX;
                default: s = SAMPLE_W'($urandom);
            endcase
            if (map_to_delay(s) > LONG_DELAY)
                s = SAMPLE_W'($urandom_range(0, 15));
            send_word(MODE_ADC, s);
        end
        send_word(MODE_ZC, SAMPLE_W'($urandom));
        while (fire_state != ST_IDLE) begin
            if ($urandom_range(0, 99) < 85)
                send_word(MODE_TICK, SAMPLE_W'($urandom));
            else
                send_noise(1);
        end
        repeat ($urandom_range(0, 2)) send_word(MODE_TICK, SAMPLE_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers and delay after reset; fire once on the shortest reset-range delay
    task automatic test_reset_defaults();
        check_register(REG_PULSE_WIDTH, 32'(PULSE_WIDTH_RST));
        check_register(REG_DELAY_MIN, 32'(DELAY_MIN_RST));
        check_register(REG_DELAY_MAX, 32'(DELAY_MAX_RST));
        no_idle = 1'b1;
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_UNUSED, 12'hFFF);
        send_word(MODE_ADC, ADC_CODE_MAX);
        send_word(MODE_ADC, 12'h000);
        send_word(MODE_ZC, 12'h000);
        run_out_pulse();
        no_idle = 1'b0;
    endtask

    // Zero delay, overlapping crossings, samples while busy, ignored kind,
    // zero pulse width and inverted ranges
    task automatic test_directed_cases();
        write_settings(10'd2, 14'd0, 14'h3FFF);
        send_word(MODE_ADC, 12'h000);
        send_word(MODE_ZC, 12'h000);
        send_word(MODE_ZC, 12'hFFF);
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_TICK, 12'hFFF);
        send_word(MODE_UNUSED, 12'hABC);
        send_word(MODE_ADC, 12'h001);
        send_word(MODE_ZC, 12'h000);
        send_word(MODE_ADC, ADC_CODE_MAX);
        send_word(MODE_ZC, 12'h000);
        run_out_pulse();
        send_word(MODE_ADC, 12'h555);
        send_word(MODE_ADC, 12'hAAA);
        send_word(MODE_ADC, 12'h000);

        write_settings(10'd0, 14'd0, 14'h3FFF);
        send_word(MODE_ADC, 12'h000);
        send_word(MODE_ZC, 12'h000);
        send_word(MODE_TICK, 12'h000);

        write_settings(10'd4, 14'd50, 14'd10);
        send_word(MODE_ADC, ADC_CODE_MAX);
        send_word(MODE_ADC, 12'h000);
        send_word(MODE_ADC, 12'h800);

        write_settings(10'd5, 14'h3FFF, 14'd0);
        send_word(MODE_ADC, ADC_CODE_MAX);
    endtask

    // Largest register values and delays at the top of the range
    task automatic test_range_limits();
        write_settings(10'h3FF, 14'h3FFF, 14'h3FFF);
        no_idle = 1'b1;
        send_word(MODE_ADC, SAMPLE_W'($urandom));
        send_word(MODE_ADC, ADC_CODE_MAX);
        no_idle = 1'b0;
        write_settings(10'h3FF, 14'd0, 14'h3FFF);
        send_word(MODE_ADC, ADC_CODE_MAX);
        send_word(MODE_ADC, 12'hFFE);
        send_word(MODE_ADC, 12'h001);
    endtask

    // Random firing cycles over several register settings
    task automatic test_random_firing();
        int base;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_settings(10'd1, 14'd0, 14'd0);
                1: write_settings(10'd3, 14'd2, 14'd40);
                2: write_settings(10'd6, 14'd30, 14'd5);
                3: write_settings(PULSE_W'($urandom_range(1, 10)),
                                  DELAY_W'($urandom_range(0, 10)),
                                  DELAY_W'($urandom_range(0, 80)));
                4: write_settings(10'd12, 14'd0, 14'h3FFF);
                default: write_settings(PULSE_W'($urandom_range(1, 16)),
                                        DELAY_W'($urandom_range(0, 30)),
                                        DELAY_W'($urandom_range(0, 100)));
            endcase
            // One phase runs flat out with no gaps on either side
            no_idle = (ph == 3);
            base = words_sent;
            while (words_sent - base < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 2)
                    send_noise($urandom_range(1, 5));
                else
                    fire_cycle();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_range_limits();
        test_random_firing();

        // Drain everything still in flight before judging
        settle_block();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
